// File: design/generational_handle_table_core_macros.svh
// Assertion macros shared by the handle table checker.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef GENERATIONAL_HANDLE_TABLE_CORE_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_CORE_MACROS_SVH

// Property checked on every rising edge outside of reset.
`define GHT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("handle table check failed");

// Property checked on every rising edge, reset included.
`define GHT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("handle table reset check failed");

`endif

// File: design/ght_pkg.sv
// Shared types and constants for the generational handle table.
// Depends on nothing; imported by ght_slot_mem, ght_ctrl and the top level.
package ght_pkg;

  // Default number of slots in the table.
  localparam int SLOT_COUNT_DEF = 16;

  // Largest generation before it wraps back to one.
  localparam logic [23:0] GEN_MAX = 24'hFF_FFFF;

  // Request codes.
  typedef enum logic [2:0] {
    OP_ALLOC          = 3'd0,
    OP_LOOKUP         = 3'd1,
    OP_RELEASE        = 3'd2,
    OP_SET_SLOT_ERR   = 3'd3,
    OP_SET_GLOBAL_ERR = 3'd4
  } ght_op_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_CHECK = 4'b0100,
    S_DONE  = 4'b1000
  } ght_state_t;

  // Commands from the sequencer to the slot store.
  typedef struct packed {
    logic        we_handle;
    logic        we_err;
    logic        set_used;
    logic        clr_used;
    logic [7:0]  wr_slot;
    logic [31:0] wr_handle;
    logic [31:0] wr_err;
    logic [7:0]  rd_slot;
    logic [7:0]  scan_slot;
  } ght_mem_cmd_t;

  // Answers from the slot store.
  typedef struct packed {
    logic        scan_used;
    logic [31:0] rd_handle;
    logic [31:0] rd_err;
  } ght_mem_rsp_t;

  // One finished result, without the global error.
  typedef struct packed {
    logic        ok;
    logic [31:0] handle;
    logic [7:0]  slot;
    logic [31:0] serr;
  } ght_res_t;

endpackage

// File: design/ght_slot_mem.sv
// Slot store: handle and sticky error memories plus per-slot used bits.
// Depends on ght_pkg for the command and response structs.
module ght_slot_mem import ght_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  ght_mem_cmd_t cmd,
  output ght_mem_rsp_t rsp
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [31:0]           handle_mem [SLOT_COUNT];
  logic [31:0]           err_mem    [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] used_r;
  logic [31:0]           rd_handle_r;
  logic [31:0]           rd_err_r;
  logic                  rd_used_r;

  // Used bits: a slot that is not in use reads as free with no error.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.set_used) begin
      used_r[cmd.wr_slot[IDX_W-1:0]] <= 1'b1;
    end else if (cmd.clr_used) begin
      used_r[cmd.wr_slot[IDX_W-1:0]] <= 1'b0;
    end
  end

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (cmd.we_handle) begin
      handle_mem[cmd.wr_slot[IDX_W-1:0]] <= cmd.wr_handle;
    end
    if (cmd.we_err) begin
      err_mem[cmd.wr_slot[IDX_W-1:0]] <= cmd.wr_err;
    end
    rd_handle_r <= handle_mem[cmd.rd_slot[IDX_W-1:0]];
    rd_err_r    <= err_mem[cmd.rd_slot[IDX_W-1:0]];
    rd_used_r   <= used_r[cmd.rd_slot[IDX_W-1:0]];
  end

  // Free-slot check for the allocation scan and masked read data.
  always_comb begin
    rsp.scan_used = used_r[cmd.scan_slot[IDX_W-1:0]];
    rsp.rd_handle = rd_used_r ? rd_handle_r : 32'd0;
    rsp.rd_err    = rd_used_r ? rd_err_r : 32'd0;
  end

endmodule

// File: design/ght_ctrl.sv
// Sequencer of the handle table: slot scan, handle check, generation and
// global error registers. Depends on ght_pkg and drives ght_slot_mem.
module ght_ctrl import ght_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_opcode,
  input  logic [31:0]         in_handle,
  input  logic signed [31:0]  in_error_code,
  output ght_mem_cmd_t        mem_cmd,
  input  ght_mem_rsp_t        mem_rsp,
  input  logic                res_take,
  output logic                res_done,
  output ght_res_t            res,
  output logic signed [31:0]  global_err
);

  localparam logic [7:0] SLOT_MAX  = 8'(SLOT_COUNT);
  localparam logic [7:0] SLOT_LAST = 8'(SLOT_COUNT - 1);

  ght_state_t  state_r, state_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [31:0] h_r, h_nxt;
  logic [31:0] err_r, err_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [23:0] gen_r, gen_nxt;
  logic [31:0] gerr_r, gerr_nxt;
  ght_res_t    res_r, res_nxt;
  logic [7:0]  in_slot_num;
  logic [23:0] gen_step;
  logic [7:0]  chk_slot;
  logic [31:0] sticky_err;

  assign in_slot_num = in_handle[7:0];
  assign gen_step    = (gen_r == GEN_MAX) ? 24'd1 : gen_r + 24'd1;
  assign chk_slot    = h_r[7:0] - 8'd1;
  // An OK value never replaces an earlier failure.
  assign sticky_err  = (err_r == 32'd0 && mem_rsp.rd_err != 32'd0) ? mem_rsp.rd_err : err_r;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    h_nxt     = h_r;
    err_nxt   = err_r;
    idx_nxt   = idx_r;
    gen_nxt   = gen_r;
    gerr_nxt  = gerr_r;
    res_nxt   = res_r;
    mem_cmd           = '0;
    mem_cmd.wr_slot   = idx_r;
    mem_cmd.rd_slot   = in_slot_num - 8'd1;
    mem_cmd.scan_slot = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_opcode;
          h_nxt   = in_handle;
          err_nxt = in_error_code;
          idx_nxt = 8'd0;
          res_nxt = '0;
          unique case (in_opcode) inside
            OP_ALLOC: begin
              state_nxt = S_SCAN;
            end
            OP_LOOKUP, OP_RELEASE, OP_SET_SLOT_ERR: begin
              if (in_slot_num == 8'd0 || in_slot_num > SLOT_MAX) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_CHECK;
              end
            end
            OP_SET_GLOBAL_ERR: begin
              gerr_nxt   = in_error_code;
              res_nxt.ok = 1'b1;
              state_nxt  = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        // One slot per cycle; the first free one is taken.
        if (!mem_rsp.scan_used) begin
          gen_nxt            = gen_step;
          mem_cmd.we_handle  = 1'b1;
          mem_cmd.we_err     = 1'b1;
          mem_cmd.set_used   = 1'b1;
          mem_cmd.wr_handle  = {gen_step, idx_r + 8'd1};
          mem_cmd.wr_err     = 32'd0;
          res_nxt.ok         = 1'b1;
          res_nxt.handle     = {gen_step, idx_r + 8'd1};
          res_nxt.slot       = idx_r;
          res_nxt.serr       = 32'd0;
          state_nxt          = S_DONE;
        end else if (idx_r == SLOT_LAST) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 8'd1;
        end
      end
      S_CHECK: begin
        // The stored handle must match exactly, so stale handles fail.
        mem_cmd.wr_slot = chk_slot;
        if (mem_rsp.rd_handle == h_r) begin
          res_nxt.ok     = 1'b1;
          res_nxt.handle = h_r;
          res_nxt.slot   = chk_slot;
          case (op_r)
            OP_RELEASE: begin
              mem_cmd.clr_used = 1'b1;
              res_nxt.serr     = 32'd0;
            end
            OP_SET_SLOT_ERR: begin
              mem_cmd.we_err = 1'b1;
              mem_cmd.wr_err = sticky_err;
              res_nxt.serr   = sticky_err;
            end
            default: begin
              res_nxt.serr = mem_rsp.rd_err;
            end
          endcase
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and table state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gen_r   <= 24'd0;
      gerr_r  <= 32'd0;
    end else begin
      state_r <= state_nxt;
      gen_r   <= gen_nxt;
      gerr_r  <= gerr_nxt;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    h_r   <= h_nxt;
    err_r <= err_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
  end

  assign in_stall   = (state_r != S_IDLE);
  assign res_done   = (state_r == S_DONE);
  assign res        = res_r;
  assign global_err = gerr_r;

endmodule

// File: design/generational_handle_table_core.sv
// Generational handle table. A request is taken only while the block is idle.
// Allocate scans the slots one per cycle through the free-slot check and
// stops at the first free slot or at the last one; lookup, release and set
// slot error do one memory read and one compare, which are skipped when the
// slot number in the handle is zero or past the table, and set global error
// or an unused code goes straight to the result. The result sits in an output
// register, so the next request is accepted while a finished result still
// waits to be taken.
// Depends on ght_pkg, ght_ctrl and ght_slot_mem.
module generational_handle_table_core import ght_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic [31:0]        in_handle,
  input  logic signed [31:0] in_error_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ok,
  output logic [31:0]        out_handle_out,
  output logic [7:0]         out_slot_number,
  output logic signed [31:0] out_slot_error,
  output logic signed [31:0] out_global_error
);

  ght_mem_cmd_t       mem_cmd;
  ght_mem_rsp_t       mem_rsp;
  ght_res_t           res;
  logic               res_done;
  logic               res_take;
  logic signed [31:0] global_err;
  logic               out_valid_r;
  ght_res_t           out_res_r;
  logic signed [31:0] out_gerr_r;

  ght_ctrl #(.SLOT_COUNT(SLOT_COUNT)) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_handle     (in_handle),
    .in_error_code (in_error_code),
    .mem_cmd       (mem_cmd),
    .mem_rsp       (mem_rsp),
    .res_take      (res_take),
    .res_done      (res_done),
    .res           (res),
    .global_err    (global_err)
  );

  ght_slot_mem #(.SLOT_COUNT(SLOT_COUNT)) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mem_cmd),
    .rsp   (mem_rsp)
  );

  // The output register takes a result whenever it is empty or being drained.
  assign res_take = res_done && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_take || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r  <= res;
      out_gerr_r <= global_err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_res_r.ok;
  assign out_handle_out   = out_res_r.handle;
  assign out_slot_number  = out_res_r.slot;
  assign out_slot_error   = out_res_r.serr;
  assign out_global_error = out_gerr_r;

endmodule

// File: design/ght_checker.sv
// Port-level checks for the generational handle table, bound to the top level.
// Depends on generational_handle_table_core_macros.svh.
`include "generational_handle_table_core_macros.svh"

module ght_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_ok,
  input logic [31:0]        out_handle_out,
  input logic [7:0]         out_slot_number,
  input logic signed [31:0] out_slot_error,
  input logic signed [31:0] out_global_error
);

  logic [104:0] out_beat;
  logic         fields_zero;
  logic         slot_tag_ok;

  // Whole result beat and the field relations checked below.
  assign out_beat    = {out_ok, out_handle_out, out_slot_number, out_slot_error,
                        out_global_error};
  assign fields_zero = (out_handle_out == 32'd0) && (out_slot_number == 8'd0) &&
                       (out_slot_error == 32'sd0);
  assign slot_tag_ok = (out_handle_out[7:0] == out_slot_number + 8'd1);

  // A stalled result beat holds.
  `GHT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_beat))

  // The block is busy right after it takes a request.
  `GHT_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall)

  // A failed request reports no handle, slot or slot error.
  `GHT_ASSERT(a_fail_zero, out_valid && !out_ok |-> fields_zero)

  // A reported handle names its own slot in the low byte.
  `GHT_ASSERT(a_slot_tag, out_valid && out_ok && out_handle_out != 32'd0 |-> slot_tag_ok)

  // Reset leaves no result pending.
  `GHT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

endmodule

bind generational_handle_table_core ght_checker u_ght_checker (.*);
